// ===== rtl/hfcg_pkg.sv =====
// shared types, register indexes and divider constants of the coefficient generator
`default_nettype none
package hfcg_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_GAMMA_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHARPNESS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_ROWS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_COLS = 3'd5;

  // flags that ride along with each word
  typedef struct packed {
    logic big;      // exponent argument past the range, exp term is zero
    logic d2_zero;  // coordinate sits on the center
  } tag_t;

  // ceil(2^34 / n) for the series terms
  function automatic logic [34:0] term_recip(input logic [3:0] n);
    logic [34:0] m;
    case (n)
      4'd1:    m = 35'd17179869184;
      4'd2:    m = 35'd8589934592;
      4'd3:    m = 35'd5726623062;
      4'd4:    m = 35'd4294967296;
      4'd5:    m = 35'd3435973837;
      4'd6:    m = 35'd2863311531;
      4'd7:    m = 35'd2454267027;
      4'd8:    m = 35'd2147483648;
      4'd9:    m = 35'd1908874354;
      4'd10:   m = 35'd1717986919;
      4'd11:   m = 35'd1561806290;
      4'd12:   m = 35'd1431655766;
      default: m = 35'd0;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hfcg_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module hfcg_div_pipe #(
  parameter int QW = 30,
  parameter int DW = 18
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [DW-1:0] in_rem,
  input  wire logic [QW-1:0] in_low,
  input  wire logic [DW-1:0] in_div,
  input  hfcg_pkg::tag_t     in_tag,
  output logic               out_valid,
  output logic [QW-1:0]      out_quot,
  output hfcg_pkg::tag_t     out_tag
);
  import hfcg_pkg::*;

  logic [QW-1:0] vld;
  logic [DW-1:0] rem  [QW];
  logic [QW-1:0] low  [QW];
  logic [QW-1:0] quot [QW];
  logic [DW-1:0] dv   [QW];
  tag_t          tg   [QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[QW-2:0], in_valid};
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW-1:0] c_rem;
    logic [QW-1:0] c_low;
    logic [QW-1:0] c_quot;
    logic [DW-1:0] c_dv;
    tag_t          c_tg;
    logic [DW:0]   trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign c_rem  = in_rem;
      assign c_low  = in_low;
      assign c_quot = '0;
      assign c_dv   = in_div;
      assign c_tg   = in_tag;
    end else begin : g_next
      assign c_rem  = rem[i-1];
      assign c_low  = low[i-1];
      assign c_quot = quot[i-1];
      assign c_dv   = dv[i-1];
      assign c_tg   = tg[i-1];
    end

    assign trial = {c_rem, c_low[QW-1]};
    assign ge    = trial >= {1'b0, c_dv};

    always_ff @(posedge clk) begin
      rem[i]  <= ge ? DW'(trial - {1'b0, c_dv}) : trial[DW-1:0];
      low[i]  <= {c_low[QW-2:0], 1'b0};
      quot[i] <= {c_quot[QW-2:0], ge};
      dv[i]   <= c_dv;
      tg[i]   <= c_tg;
    end
  end

  assign out_valid = vld[QW-1];
  assign out_quot  = quot[QW-1];
  assign out_tag   = tg[QW-1];

endmodule
`default_nettype wire

// ===== rtl/homomorphic_filter_coefficient_gen_top.sv =====
// homomorphic gaussian high-emphasis coefficient generator, fully pipelined
// done rises for a word once it has passed the distance stages, the bit-per-stage
//   argument divider, the exp series stages, the reciprocal divider, squarings and output stages
// throughput: one coordinate word per cycle, busy never rises
// reset: synchronous rst clears registers to zero gains and MAX_SIDE plane size
// and empties the pipe; done is a one-cycle strobe the receiver cannot stall
`default_nettype none
module homomorphic_filter_coefficient_gen_top #(
  parameter int unsigned MAX_SIDE  = 4096,
  parameter int unsigned FRAC_BITS = 12
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [11:0]                      row_index,
  input  wire logic [11:0]                      col_index,
  input  wire logic                             cfg_we,
  input  wire logic [hfcg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hfcg_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                  done,
  output logic [15:0]                           coefficient
);
  import hfcg_pkg::*;

  // final divide by ten via reciprocal
  localparam int K10  = FRAC_BITS + 12;
  localparam int M10W = FRAC_BITS + 9;
  localparam int W5W  = FRAC_BITS + 8;
  localparam int QOW  = W5W + M10W - K10;
  localparam logic [M10W-1:0] M10 = M10W'(((64'd1 << K10) + 64'd9) / 64'd10);
  localparam logic [12:0] SIDE_RST = 13'(MAX_SIDE);
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // configuration registers
  logic [6:0]  gamma_high;
  logic [6:0]  gamma_low;
  logic [6:0]  cutoff;
  logic [6:0]  sharpness;
  logic [12:0] plane_rows;
  logic [12:0] plane_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_high <= '0;
      gamma_low  <= '0;
      cutoff     <= '0;
      sharpness  <= '0;
      plane_rows <= SIDE_RST;
      plane_cols <= SIDE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAMMA_HIGH: gamma_high <= cfg_data[6:0];
        REG_GAMMA_LOW:  gamma_low  <= cfg_data[6:0];
        REG_CUTOFF:     cutoff     <= cfg_data[6:0];
        REG_SHARPNESS:  sharpness  <= cfg_data[6:0];
        REG_PLANE_ROWS: plane_rows <= cfg_data;
        REG_PLANE_COLS: plane_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // divisor 10*d0^2 and the 48x range limit, refreshed from the cutoff register
  logic [17:0] den;
  logic [22:0] lim48;
  always_ff @(posedge clk) begin
    den   <= 18'(cutoff) * 18'(cutoff) * 18'd10;
    lim48 <= 23'(den) * 23'd48;
  end

  assign busy = 1'b0;

  // stage 1: distance to the center
  logic        v1, v2, v3, v4;
  logic [11:0] dr, dc;
  logic [11:0] half_r, half_c;
  assign half_r = plane_rows[12:1];
  assign half_c = plane_cols[12:1];

  // stage 2: squares, stage 3: d2, stage 4: numerator
  logic [23:0] sq_r, sq_c;
  logic [24:0] d2;
  logic [31:0] num;
  logic        d2z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= start & ~busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    dr   <= (row_index >= half_r) ? row_index - half_r : half_r - row_index;
    dc   <= (col_index >= half_c) ? col_index - half_c : half_c - col_index;
    sq_r <= 24'(dr) * 24'(dr);
    sq_c <= 24'(dc) * 24'(dc);
    d2   <= 25'(sq_r) + 25'(sq_c);
    num  <= 32'(sharpness) * 32'(d2);
    d2z  <= (d2 == '0);
  end

  // y = floor(num * 2^24 / den), x/64 in q30
  tag_t        div1_tag_in;
  logic        d1_valid;
  logic [29:0] d1_y;
  tag_t        d1_tag;

  assign div1_tag_in.big     = num >= {9'd0, lim48};
  assign div1_tag_in.d2_zero = d2z;

  hfcg_div_pipe #(.QW(30), .DW(18)) u_div_arg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .in_rem    (num[23:6]),
    .in_low    ({num[5:0], 24'd0}),
    .in_div    (den),
    .in_tag    (div1_tag_in),
    .out_valid (d1_valid),
    .out_quot  (d1_y),
    .out_tag   (d1_tag)
  );

  // exp(y) series, two stages a term: product then divide by n
  logic [23:0] ser_v;
  logic [29:0] ta_a [12];
  logic [31:0] ta_s [12];
  logic [29:0] ta_y [12];
  tag_t        ta_tg [12];
  logic [30:0] tb_t [12];
  logic [31:0] tb_s [12];
  logic [29:0] tb_y [12];
  tag_t        tb_tg [12];

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_v <= '0;
    end else begin
      ser_v <= {ser_v[22:0], d1_valid};
    end
  end

  for (genvar j = 0; j < 12; j++) begin : g_term
    logic [30:0] c_t;
    logic [31:0] c_s;
    logic [29:0] c_y;
    tag_t        c_tg;
    logic [60:0] p_ty;
    logic [64:0] p_div;

    if (j == 0) begin : g_first
      assign c_t  = ONE_Q30;
      assign c_s  = 32'(ONE_Q30);
      assign c_y  = d1_y;
      assign c_tg = d1_tag;
    end else begin : g_next
      assign c_t  = tb_t[j-1];
      assign c_s  = tb_s[j-1];
      assign c_y  = tb_y[j-1];
      assign c_tg = tb_tg[j-1];
    end

    assign p_ty  = 61'(c_t) * 61'(c_y);
    assign p_div = 65'(ta_a[j]) * 65'(term_recip(4'(j + 1)));

    always_ff @(posedge clk) begin
      ta_a[j]  <= p_ty[59:30];
      ta_s[j]  <= c_s;
      ta_y[j]  <= c_y;
      ta_tg[j] <= c_tg;
      tb_t[j]  <= p_div[64:34];
      tb_s[j]  <= ta_s[j] + 32'(p_div[64:34]);
      tb_y[j]  <= ta_y[j];
      tb_tg[j] <= ta_tg[j];
    end
  end

  // e = floor((2^60 + s/2) / s), exp(-y) in q30
  logic        d2_valid;
  logic [30:0] d2_e;
  tag_t        d2_tag;

  hfcg_div_pipe #(.QW(31), .DW(32)) u_div_recip (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ser_v[23]),
    .in_rem    (32'h2000_0000),
    .in_low    (tb_s[11][31:1]),
    .in_div    (tb_s[11]),
    .in_tag    (tb_tg[11]),
    .out_valid (d2_valid),
    .out_quot  (d2_e),
    .out_tag   (d2_tag)
  );

  // six rounded squarings take exp(-y) to exp(-64y)
  logic [5:0]  sq_v;
  logic [30:0] sq_e  [6];
  tag_t        sq_tg [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v <= '0;
    end else begin
      sq_v <= {sq_v[4:0], d2_valid};
    end
  end

  for (genvar k = 0; k < 6; k++) begin : g_sq
    logic [30:0] c_e;
    tag_t        c_tg;
    logic [61:0] p_sq;

    if (k == 0) begin : g_first
      assign c_e  = d2_e;
      assign c_tg = d2_tag;
    end else begin : g_next
      assign c_e  = sq_e[k-1];
      assign c_tg = sq_tg[k-1];
    end

    assign p_sq = 62'(c_e) * 62'(c_e) + 62'h2000_0000;

    always_ff @(posedge clk) begin
      sq_e[k]  <= p_sq[60:30];
      sq_tg[k] <= c_tg;
    end
  end

  // output stages: 1-exp, gain blend, scale and round, saturate
  logic               f1_v, f2_v, f3_v;
  logic [30:0]        om;
  logic [36:0]        vsum;
  logic [W5W-1:0]     w5;
  logic signed [7:0]  gdiff;
  logic signed [39:0] gprod;
  logic signed [39:0] vfull;
  logic [W5W+M10W-1:0] p10;
  logic [QOW-1:0]     qv;

  assign gdiff = $signed({1'b0, gamma_high}) - $signed({1'b0, gamma_low});
  assign gprod = 40'(gdiff) * 40'($signed({1'b0, om}));
  assign vfull = $signed({3'd0, gamma_low, 30'd0}) + gprod;
  assign p10   = (W5W + M10W)'(w5) * (W5W + M10W)'(M10);
  assign qv    = p10[W5W+M10W-1:K10];

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
      f3_v <= 1'b0;
      done <= 1'b0;
    end else begin
      f1_v <= sq_v[5];
      f2_v <= f1_v;
      f3_v <= f2_v;
      done <= f3_v;
    end
  end

  always_ff @(posedge clk) begin
    // zero cutoff: step from gamma_low at the center to gamma_high elsewhere
    if (cutoff == '0) begin
      om <= sq_tg[5].d2_zero ? 31'd0 : ONE_Q30;
    end else if (sq_tg[5].big) begin
      om <= ONE_Q30;
    end else begin
      om <= ONE_Q30 - sq_e[5];
    end
    vsum <= vfull[36:0];
    w5   <= W5W'(vsum[36:30-FRAC_BITS]) + W5W'(5);
    if (32'(qv) > 32'd65535) begin
      coefficient <= 16'hFFFF;
    end else begin
      coefficient <= 16'(qv);
    end
  end

endmodule
`default_nettype wire
